@@ hdl/ole_pkg.sv @@
// ----------------------------------------------------------------------------
// ole_pkg
// shared types and codes of the ordered list engine
// ----------------------------------------------------------------------------
package ole_pkg;

    localparam logic [2:0] OP_ADD_FIRST  = 3'd0;
    localparam logic [2:0] OP_ADD_LAST   = 3'd1;
    localparam logic [2:0] OP_INSERT     = 3'd2;
    localparam logic [2:0] OP_REMOVE_POS = 3'd3;
    localparam logic [2:0] OP_REMOVE_VAL = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_POS  = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] data_value;
        logic [6:0]  position;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic [6:0]  list_size;
        logic        not_empty;
        logic [31:0] first_value;
        logic [31:0] last_value;
        logic [6:0]  removed_count;
    } t_rsp;

endpackage

@@ hdl/ole_if.sv @@
// ----------------------------------------------------------------------------
// ole_cmd_if / ole_rsp_if
// valid/ready channels for command and response beats
// ----------------------------------------------------------------------------
interface ole_cmd_if;
    logic          valid;
    logic          ready;
    ole_pkg::t_cmd data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ole_rsp_if;
    logic          valid;
    logic          ready;
    ole_pkg::t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/ordered_list_engine.sv @@
// ----------------------------------------------------------------------------
// ordered_list_engine
// linked list of values with a free stack, kept in on-chip memories
// ----------------------------------------------------------------------------
// One command beat in, one response beat out, one command at a time. Values
// and links live in synchronous memories with registered read ports. The
// free slots live in a stack memory that needs no clearing pass: a low-water
// mark of the stack pointer tells which stack entries were ever written, and
// an entry below the mark still reads as its own index. A full store, a bad
// position, an empty remove or an unused code go from decode straight to
// reading the ends for the response; add first, add last, insert at either
// end and remove at position 0 fetch and apply without a walk; insert at a
// middle position and remove at a position above 0 first walk from the head,
// and remove value visits every entry. Each hop of a walk passes through
// S_WALK and S_WALK_W because the next link address comes out of the
// registered read port of the link memory. The worst case is remove value
// over a full store. The response waits in its own register for the sink;
// the next command is taken only once that register is empty, so even with
// a ready sink the next command beat is accepted only after the response
// beat has been taken.
// ----------------------------------------------------------------------------
module ordered_list_engine #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    ole_cmd_if.sink   i_cmd,
    ole_rsp_if.source o_rsp
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    // states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_WALK     = 4'd2;  // hop count check, link read
    localparam logic [3:0] S_WALK_W   = 4'd3;  // link data back, step on
    localparam logic [3:0] S_FETCH    = 4'd4;  // read link of cur and free top
    localparam logic [3:0] S_APPLY    = 4'd5;  // main update
    localparam logic [3:0] S_VICTIM   = 4'd6;  // read link of removed slot
    localparam logic [3:0] S_UNLINK   = 4'd7;  // prev.link = victim.link
    localparam logic [3:0] S_INS_LINK = 4'd8;  // prev.link = new slot
    localparam logic [3:0] S_SCAN     = 4'd9;  // value removal: read cur
    localparam logic [3:0] S_SCAN_W   = 4'd10; // value removal: visit cur
    localparam logic [3:0] S_ENDS     = 4'd11; // read head and tail values
    localparam logic [3:0] S_RESP     = 4'd12;

    // memories
    logic [DATA_WIDTH-1:0] m_val  [DEPTH];
    logic [AW-1:0]         m_link [DEPTH];
    logic [AW-1:0]         m_free [DEPTH];

    logic [3:0]    r_state;
    ole_pkg::t_cmd r_cmd;
    logic [CW-1:0] r_free_cnt, r_count, r_low;
    logic [AW-1:0] r_head, r_tail, r_prev, r_cur, r_slot;
    logic          r_have_prev;
    logic [CW-1:0] r_step, r_left;
    logic [CW-1:0] r_removed;
    logic [1:0]    r_status;
    logic          r_out_valid;
    ole_pkg::t_rsp r_out;

    // memory ports
    logic                  val_we, link_we, free_we;
    logic [AW-1:0]         val_wa, link_wa, free_wa;
    logic [DATA_WIDTH-1:0] val_wd;
    logic [AW-1:0]         link_wd, free_wd;
    logic [AW-1:0]         val_ra, val_ra2, link_ra, free_ra;
    logic [DATA_WIDTH-1:0] val_rd, val_rd2;
    logic [AW-1:0]         link_rd, free_rd;

    always_ff @(posedge i_clk) begin
        if (val_we) m_val[val_wa] <= val_wd;
        val_rd  <= m_val[val_ra];
        val_rd2 <= m_val[val_ra2];
    end
    always_ff @(posedge i_clk) begin
        if (link_we) m_link[link_wa] <= link_wd;
        link_rd <= m_link[link_ra];
    end
    always_ff @(posedge i_clk) begin
        if (free_we) m_free[free_wa] <= free_wd;
        free_rd <= m_free[free_ra];
    end

    // stack top; entries below the low-water mark were never written
    logic [CW-1:0] free_pop_cnt;
    logic [AW-1:0] free_top;
    assign free_pop_cnt = r_free_cnt - CW'(1);
    assign free_top     = (free_pop_cnt >= r_low) ? free_rd : free_pop_cnt[AW-1:0];

    wire [DATA_WIDTH-1:0] cmd_val = DATA_WIDTH'(r_cmd.data_value);
    wire [CW-1:0] cmd_pos = CW'(r_cmd.position);
    wire pos_ok = ({25'd0, r_cmd.position} <= 32'(DEPTH));
    wire scan_hit = (val_rd == cmd_val);

    assign i_cmd.ready = (r_state == S_IDLE) && !r_out_valid;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    // read addresses follow the registers of the walk
    assign link_ra = r_cur;
    assign val_ra  = (r_state == S_ENDS) ? r_head : r_cur;
    assign val_ra2 = r_tail;
    assign free_ra = free_pop_cnt[AW-1:0];

    // write controls
    always_comb begin
        val_we  = 1'b0;
        val_wa  = free_top;
        val_wd  = cmd_val;
        link_we = 1'b0;
        link_wa = free_top;
        link_wd = r_head;
        free_we = 1'b0;
        free_wa = r_free_cnt[AW-1:0];
        free_wd = r_cur;
        case (r_state)
            S_APPLY: begin
                case (r_cmd.operation)
                    ole_pkg::OP_ADD_FIRST: begin
                        val_we  = 1'b1;
                        link_we = 1'b1;
                        link_wd = (r_count == '0) ? '0 : r_head;
                    end
                    ole_pkg::OP_ADD_LAST: begin
                        val_we  = 1'b1;
                        link_we = (r_count != '0);
                        link_wa = r_tail;
                        link_wd = free_top;
                    end
                    ole_pkg::OP_INSERT: begin
                        // new slot takes over the next link of prev
                        val_we  = 1'b1;
                        link_we = 1'b1;
                        link_wd = link_rd;
                    end
                    ole_pkg::OP_REMOVE_POS: begin
                        free_we = 1'b1;
                        free_wd = (cmd_pos == '0) ? r_cur : link_rd;
                    end
                    default: ;
                endcase
            end
            S_INS_LINK: begin
                link_we = 1'b1;
                link_wa = r_cur;
                link_wd = r_slot;
            end
            S_UNLINK: begin
                link_we = 1'b1;
                link_wa = r_prev;
                link_wd = link_rd;
            end
            S_SCAN_W: begin
                if (scan_hit) begin
                    free_we = 1'b1;
                    link_we = r_have_prev;
                    link_wa = r_prev;
                    link_wd = link_rd;
                end
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free_cnt  <= FULL_CNT;
            r_low       <= FULL_CNT;
            r_count     <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_RESP) r_out_valid <= 1'b1;
            else if (r_out_valid && o_rsp.ready) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid && i_cmd.ready) begin
                        r_cmd     <= i_cmd.data;
                        r_removed <= '0;
                        r_status  <= ole_pkg::ST_OK;
                        r_state   <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_cur       <= r_head;
                    r_step      <= '0;
                    r_have_prev <= 1'b0;
                    r_left      <= r_count;
                    r_state     <= S_ENDS;
                    case (r_cmd.operation)
                        ole_pkg::OP_ADD_FIRST, ole_pkg::OP_ADD_LAST: begin
                            if (r_free_cnt == '0) r_status <= ole_pkg::ST_FULL;
                            else r_state <= S_FETCH;
                        end
                        ole_pkg::OP_INSERT: begin
                            if (!pos_ok || cmd_pos > r_count)
                                r_status <= ole_pkg::ST_BAD_POS;
                            else if (r_free_cnt == '0)
                                r_status <= ole_pkg::ST_FULL;
                            else if (cmd_pos == '0) begin
                                r_cmd.operation <= ole_pkg::OP_ADD_FIRST;
                                r_state <= S_FETCH;
                            end else if (cmd_pos == r_count) begin
                                r_cmd.operation <= ole_pkg::OP_ADD_LAST;
                                r_state <= S_FETCH;
                            end else
                                r_state <= S_WALK;
                        end
                        ole_pkg::OP_REMOVE_POS: begin
                            if (r_count == '0) ;  // empty list: nothing to do
                            else if (!pos_ok || cmd_pos >= r_count)
                                r_status <= ole_pkg::ST_BAD_POS;
                            else if (cmd_pos == '0) r_state <= S_FETCH;
                            else r_state <= S_WALK;
                        end
                        ole_pkg::OP_REMOVE_VAL: begin
                            if (r_count != '0) r_state <= S_SCAN;
                        end
                        default: ;
                    endcase
                end
                // walk to prev, position-1 hops from head
                S_WALK: begin
                    if (r_step == cmd_pos - CW'(1)) r_state <= S_FETCH;
                    else r_state <= S_WALK_W;
                end
                S_WALK_W: begin
                    r_cur   <= link_rd;
                    r_step  <= r_step + CW'(1);
                    r_state <= S_WALK;
                end
                S_FETCH: r_state <= S_APPLY;
                S_APPLY: begin
                    r_state <= S_ENDS;
                    case (r_cmd.operation)
                        ole_pkg::OP_ADD_FIRST: begin
                            r_head <= free_top;
                            if (r_count == '0) r_tail <= free_top;
                            if (free_pop_cnt < r_low) r_low <= free_pop_cnt;
                            r_free_cnt <= free_pop_cnt;
                            r_count    <= r_count + CW'(1);
                        end
                        ole_pkg::OP_ADD_LAST: begin
                            r_tail <= free_top;
                            if (r_count == '0) r_head <= free_top;
                            if (free_pop_cnt < r_low) r_low <= free_pop_cnt;
                            r_free_cnt <= free_pop_cnt;
                            r_count    <= r_count + CW'(1);
                        end
                        ole_pkg::OP_INSERT: begin
                            r_slot <= free_top;
                            if (free_pop_cnt < r_low) r_low <= free_pop_cnt;
                            r_free_cnt <= free_pop_cnt;
                            r_count    <= r_count + CW'(1);
                            r_state    <= S_INS_LINK;
                        end
                        ole_pkg::OP_REMOVE_POS: begin
                            r_removed  <= CW'(1);
                            r_count    <= r_count - CW'(1);
                            r_free_cnt <= r_free_cnt + CW'(1);
                            if (cmd_pos == '0) begin
                                // head leaves; an emptied list parks at slot 0
                                r_head <= (r_count == CW'(1)) ? '0 : link_rd;
                                if (r_count == CW'(1)) r_tail <= '0;
                            end else if (link_rd == r_tail) begin
                                r_tail <= r_cur;
                            end else begin
                                // victim in the middle: fetch its link
                                r_prev  <= r_cur;
                                r_cur   <= link_rd;
                                r_state <= S_VICTIM;
                            end
                        end
                        default: ;
                    endcase
                end
                S_VICTIM:   r_state <= S_UNLINK;
                S_UNLINK:   r_state <= S_ENDS;
                S_INS_LINK: r_state <= S_ENDS;
                // value scan: read value and link of cur, then visit
                S_SCAN: r_state <= S_SCAN_W;
                S_SCAN_W: begin
                    r_left <= r_left - CW'(1);
                    r_cur  <= link_rd;
                    if (scan_hit) begin
                        if (r_count == CW'(1)) r_head <= '0;
                        else if (!r_have_prev) r_head <= link_rd;
                        if (r_count == CW'(1)) r_tail <= '0;
                        else if (r_left == CW'(1)) r_tail <= r_have_prev ? r_prev : '0;
                        r_free_cnt <= r_free_cnt + CW'(1);
                        r_count    <= r_count - CW'(1);
                        r_removed  <= r_removed + CW'(1);
                    end else begin
                        r_prev      <= r_cur;
                        r_have_prev <= 1'b1;
                    end
                    r_state <= (r_left == CW'(1)) ? S_ENDS : S_SCAN;
                end
                S_ENDS: r_state <= S_RESP;
                S_RESP: begin
                    r_out.status        <= r_status;
                    r_out.list_size     <= 7'(r_count);
                    r_out.not_empty     <= (r_count != '0);
                    r_out.first_value   <= (r_count != '0) ? 32'(val_rd) : '0;
                    r_out.last_value    <= (r_count != '0) ? 32'(val_rd2) : '0;
                    r_out.removed_count <= 7'(r_removed);
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count + r_free_cnt) == FULL_CNT)
        else $error("count and free count disagree");
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_rsp.ready |=> r_out_valid && $stable(r_out))
        else $error("response changed while stalled");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ready |-> r_state == S_IDLE)
        else $error("command taken while busy");
`endif

endmodule

@@ tb/sv/ordered_list_engine_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_engine_tb
// self-checking bench: directed rows, fill to full, random traffic under stalls
// ----------------------------------------------------------------------------
// A queue-based model of the list predicts every response beat. Commands
// are driven on the falling edge and beats are sampled on the rising edge.
// The random part mostly grows the list toward full and drains it again,
// so the full store, bad positions and empty removes are all reached.
// ----------------------------------------------------------------------------
module ordered_list_engine_tb;

    localparam int DEPTH       = 64;
    localparam int N_RANDOM    = 810;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    always #4 i_clk = ~i_clk;

    ole_cmd_if cmd_if ();
    ole_rsp_if rsp_if ();

    ordered_list_engine #(.DEPTH(DEPTH), .DATA_WIDTH(32)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if.sink),
        .o_rsp   (rsp_if.source)
    );

    // predicted list contents, head at index 0
    logic [31:0]   list_vals[$];
    ole_pkg::t_rsp rsp_expected[$];
    int            mismatches = 0;
    int            beats_checked = 0;
    int            cycles = 0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            hold_off = 0;
    bit            long_hold_req = 1'b0;
    bit            long_hold_done = 1'b0;
    int            n_full = 0;
    int            n_bad_pos = 0;

    // apply one command to the list model and return the response it gives
    function automatic ole_pkg::t_rsp list_apply(ole_pkg::t_cmd c);
        ole_pkg::t_rsp r;
        int            n;
        r = '0;
        n = list_vals.size();
        case (c.operation)
            ole_pkg::OP_ADD_FIRST, ole_pkg::OP_ADD_LAST: begin
                if (n == DEPTH) r.status = ole_pkg::ST_FULL;
                else if (c.operation == ole_pkg::OP_ADD_FIRST)
                    list_vals.push_front(c.data_value);
                else list_vals.push_back(c.data_value);
            end
            ole_pkg::OP_INSERT: begin
                if (c.position > n) r.status = ole_pkg::ST_BAD_POS;
                else if (n == DEPTH) r.status = ole_pkg::ST_FULL;
                else list_vals.insert(c.position, c.data_value);
            end
            ole_pkg::OP_REMOVE_POS: begin
                if (n == 0) begin
                    // empty list: accepted without change
                end else if (c.position >= n) begin
                    r.status = ole_pkg::ST_BAD_POS;
                end else begin
                    list_vals.delete(c.position);
                    r.removed_count = 7'd1;
                end
            end
            ole_pkg::OP_REMOVE_VAL: begin
                for (int i = n - 1; i >= 0; i--) begin
                    if (list_vals[i] == c.data_value) begin
                        list_vals.delete(i);
                        r.removed_count++;
                    end
                end
            end
            default: ;
        endcase
        r.list_size = 7'(list_vals.size());
        r.not_empty = list_vals.size() != 0;
        if (r.not_empty) begin
            r.first_value = list_vals[0];
            r.last_value  = list_vals[$];
        end
        return r;
    endfunction

    // drive one beat, waiting for acceptance, with random idle first
    task automatic send_cmd(ole_pkg::t_cmd c);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.data  <= c;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // random value, half the time from a small pool so removal by value finds matches
    function automatic logic [31:0] pick_value();
        case ($urandom_range(3))
            0: return $urandom_range(7);
            1: return 32'hFFFF_FFF8 | $urandom_range(7);
            default: return $urandom();
        endcase
    endfunction

    function automatic ole_pkg::t_cmd pick_cmd(int bias_grow);
        ole_pkg::t_cmd c;
        int            n;
        int            r;
        n = list_vals.size();
        r = $urandom_range(99);
        c.data_value = pick_value();
        c.position   = 7'($urandom_range(n + 1 > 64 ? 64 : n + 1));
        if ($urandom_range(15) == 0) c.position = 7'($urandom_range(127));
        if (r < bias_grow) begin
            c.operation = 3'(ole_pkg::OP_ADD_FIRST + $urandom_range(2));
        end else if (r < 92) begin
            c.operation = ole_pkg::OP_REMOVE_POS;
            if (n > 0 && $urandom_range(3) != 0) c.position = 7'($urandom_range(n - 1));
        end else begin
            c.operation = ole_pkg::OP_REMOVE_VAL;
            if (n > 0 && $urandom_range(1)) c.data_value = list_vals[$urandom_range(n - 1)];
        end
        return c;
    endfunction

    // directed table: expected response typed in where it is obvious
    typedef struct {
        ole_pkg::t_cmd c;
        bit            known;
        ole_pkg::t_rsp r;
    } t_row;

    t_row dir_rows[$];

    task automatic add_row(logic [2:0] op, logic [31:0] v, logic [6:0] p,
                           bit known, ole_pkg::t_rsp r);
        t_row row;
        row.c.operation  = op;
        row.c.data_value = v;
        row.c.position   = p;
        row.known        = known;
        row.r            = r;
        dir_rows.push_back(row);
    endtask

    // receiver: stalls at random, with one long hold-off when requested
    always @(negedge i_clk) begin
        if (long_hold_req && !long_hold_done) begin
            long_hold_done <= 1'b1;
            hold_off <= HOLD_CYCLES - 1;
            rsp_if.ready <= 1'b0;
        end else if (hold_off > 0) begin
            rsp_if.ready <= 1'b0;
            hold_off <= hold_off - 1;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // check every accepted response beat against the oldest prediction
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (rsp_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected response beat %p", rsp_if.data);
            end else begin
                ole_pkg::t_rsp e;
                e = rsp_expected.pop_front();
                beats_checked++;
                if (rsp_if.data !== e) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("beat %0d mismatch: expected %p actual %p",
                                 beats_checked, e, rsp_if.data);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("ordered_list_engine_tb NOT OK");
            $finish;
        end
    end

    initial begin
        ole_pkg::t_cmd c;
        ole_pkg::t_rsp r;
        ole_pkg::t_rsp z;
        int            wait_cycles;
        cmd_if.valid = 1'b0;
        cmd_if.data  = '0;
        rsp_if.ready = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed rows
        z = '0;
        add_row(ole_pkg::OP_REMOVE_POS, 0, 0, 1, z);            // remove from empty
        add_row(ole_pkg::OP_REMOVE_VAL, 5, 0, 1, z);            // value remove, empty
        r = z; r.status = ole_pkg::ST_BAD_POS;
        add_row(ole_pkg::OP_INSERT, 1, 1, 1, r);                // insert beyond size
        r = z; r.list_size = 1; r.not_empty = 1;
        r.first_value = 32'hFFFF_FFFF; r.last_value = 32'hFFFF_FFFF;
        add_row(ole_pkg::OP_ADD_FIRST, 32'hFFFF_FFFF, 0, 1, r);
        add_row(ole_pkg::OP_ADD_LAST, 0, 0, 0, z);
        add_row(ole_pkg::OP_INSERT, 32'h5555_AAAA, 1, 0, z);    // middle insert
        add_row(ole_pkg::OP_INSERT, 32'hAAAA_5555, 0, 0, z);
        add_row(ole_pkg::OP_INSERT, 7, 4, 0, z);                // insert at size
        add_row(ole_pkg::OP_REMOVE_POS, 0, 127, 0, z);          // bad position
        add_row(ole_pkg::OP_REMOVE_POS, 0, 2, 0, z);
        add_row(ole_pkg::OP_REMOVE_POS, 0, 2, 0, z);            // middle remove
        add_row(ole_pkg::OP_ADD_LAST, 7, 0, 0, z);
        add_row(ole_pkg::OP_REMOVE_VAL, 7, 0, 0, z);            // removes two
        add_row(ole_pkg::OP_REMOVE_VAL, 123, 0, 0, z);          // no match
        add_row(3'd5, 1, 0, 0, z);                              // unused codes
        add_row(3'd7, 1, 0, 0, z);
        add_row(ole_pkg::OP_REMOVE_VAL, 32'hAAAA_5555, 0, 0, z);
        add_row(ole_pkg::OP_REMOVE_POS, 0, 0, 0, z);            // last entry out
        foreach (dir_rows[i]) begin
            r = list_apply(dir_rows[i].c);
            if (dir_rows[i].known && r !== dir_rows[i].r) begin
                mismatches++;
                $display("directed row %0d: table disagrees with prediction", i);
            end
            rsp_expected.push_back(dir_rows[i].known ? dir_rows[i].r : r);
            send_cmd(dir_rows[i].c);
        end

        // fill to full, hit full on every insert kind, then remove the tail
        for (int i = 0; i < DEPTH; i++) begin
            c.operation = ole_pkg::OP_ADD_LAST; c.data_value = i; c.position = '0;
            rsp_expected.push_back(list_apply(c));
            send_cmd(c);
        end
        for (int k = 0; k < 3; k++) begin
            c.operation = 3'(ole_pkg::OP_ADD_FIRST + k);
            c.data_value = 1;
            c.position = 7'd64;
            rsp_expected.push_back(list_apply(c));
            send_cmd(c);
            n_full++;
        end
        c.operation = ole_pkg::OP_REMOVE_POS; c.position = 7'd63;
        rsp_expected.push_back(list_apply(c));
        send_cmd(c);

        // random phases with varying idle and stall pressure, the last with one long hold-off
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
                3: begin send_idle_pct = 12; recv_stall_pct = 12; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            if (ph == 4) long_hold_req = 1'b1;
            for (int i = 0; i < N_RANDOM / 5; i++) begin
                // alternate growth and shrink epochs to sweep the fill level
                c = pick_cmd(((i / 60) % 2 == 0) ? 80 : 25);
                r = list_apply(c);
                if (r.status == ole_pkg::ST_FULL) n_full++;
                if (r.status == ole_pkg::ST_BAD_POS) n_bad_pos++;
                rsp_expected.push_back(r);
                send_cmd(c);
            end
        end
        cmd_if.valid <= 1'b0;

        while (rsp_expected.size() != 0) @(posedge i_clk);
        wait_cycles = 0;
        while (wait_cycles < 200) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        $display("ran %0d response beats, %0d store-full and %0d bad-position results",
                 beats_checked, n_full, n_bad_pos);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0) begin
            $display("ordered_list_engine_tb OK");
        end else begin
            $display("ordered_list_engine_tb NOT OK");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/ole_pkg.sv
hdl/ole_if.sv
hdl/ordered_list_engine.sv
tb/sv/ordered_list_engine_tb.sv
